### rtl/cfr_pkg.sv
// Shared types and constants of the command frame receiver.
package cfr_pkg;

    localparam int STORE_DEPTH  = 18;
    localparam int MAX_PAYLOAD  = 49;
    localparam int PAYLOAD_W    = STORE_DEPTH * 8;
    localparam int GAIN_WORDS   = 9;
    localparam int ACK_LEN      = 7;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'hAF;
    localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
    localparam logic [7:0] FN_RATE     = 8'h10;
    localparam logic [7:0] FN_ATT      = 8'h11;
    localparam logic [7:0] FN_ACK_LO   = 8'h12;
    localparam logic [7:0] FN_ACK_HI   = 8'h15;
    localparam logic [7:0] FN_QUERY    = 8'h02;
    localparam logic [7:0] QRY_GAINS   = 8'h01;
    localparam logic [7:0] QRY_VERSION = 8'hA0;

    localparam logic [7:0] ACK_B0 = 8'hAA;
    localparam logic [7:0] ACK_B1 = 8'hAA;
    localparam logic [7:0] ACK_B2 = 8'hEF;
    localparam logic [7:0] ACK_B3 = 8'h02;
    localparam logic [7:0] ACK_CK_BASE = 8'(ACK_B0 + ACK_B1 + ACK_B2 + ACK_B3);

    localparam logic [3:0] ACK_FIRST_STEP = 4'(GAIN_WORDS);
    localparam logic [3:0] LAST_STEP      = 4'(GAIN_WORDS + ACK_LEN - 1);

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_GAIN    = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_VERSION = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HDR2 = 3'd1,
        PH_FUNC = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CSUM = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        JOB_GAINS   = 2'd0,
        JOB_ACK     = 2'd1,
        JOB_READ    = 2'd2,
        JOB_VERSION = 2'd3
    } t_job_kind;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } t_back_state;

    typedef struct packed {
        t_job_kind              kind;
        logic                   group;
        logic [7:0]             func;
        logic [7:0]             csum;
        logic [PAYLOAD_W-1:0]   payload;
    } t_job;

endpackage

### rtl/cfr_front.sv
// Frame parser: checks header, length and checksum and turns a good frame into a job.
module cfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_rx_byte,
    output logic          o_job_valid,
    output cfr_pkg::t_job o_job
);
    import cfr_pkg::*;

    t_phase     r_phase, n_phase;
    logic [5:0] r_left, n_left;
    logic [5:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_func, n_func;
    logic [7:0] r_store [STORE_DEPTH];
    logic [7:0] n_store [STORE_DEPTH];
    logic       store_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_left  <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_func  <= '0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_func  <= n_func;
            r_store <= n_store;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_count  = r_count;
        n_sum    = r_sum;
        n_func   = r_func;
        store_wr = 1'b0;
        if (i_take) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == HDR_FIRST) begin
                        n_phase = PH_HDR2;
                        n_sum   = i_rx_byte;
                    end
                end
                PH_HDR2: begin
                    if (i_rx_byte == HDR_SECOND) begin
                        n_phase = PH_FUNC;
                        n_sum   = 8'(r_sum + i_rx_byte);
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_FUNC: begin
                    if (i_rx_byte < FUNC_LIMIT) begin
                        n_phase = PH_LEN;
                        n_func  = i_rx_byte;
                        n_sum   = 8'(r_sum + i_rx_byte);
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_LEN: begin
                    if (i_rx_byte <= 8'(MAX_PAYLOAD)) begin
                        n_phase = PH_DATA;
                        n_left  = i_rx_byte[5:0];
                        n_count = '0;
                        n_sum   = 8'(r_sum + i_rx_byte);
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_DATA: begin
                    // A zero length leaves nothing to count, so the next byte is dropped.
                    if (r_left != '0) begin
                        n_left   = r_left - 6'd1;
                        n_count  = r_count + 6'd1;
                        n_sum    = 8'(r_sum + i_rx_byte);
                        store_wr = 1'b1;
                        if (r_left == 6'd1) begin
                            n_phase = PH_CSUM;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_CSUM: begin
                    n_phase  = PH_IDLE;
                    store_wr = 1'b1;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Positions beyond the store are summed but not kept; the checksum byte lands here too.
    always_comb begin
        n_store = r_store;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (store_wr && r_count == 6'(i)) begin
                n_store[i] = i_rx_byte;
            end
        end
    end

    always_comb begin
        o_job_valid = 1'b0;
        o_job.kind  = JOB_ACK;
        o_job.group = r_func[0];
        o_job.func  = r_func;
        o_job.csum  = r_sum;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            o_job.payload[PAYLOAD_W-1-8*i -: 8] = n_store[i];
        end
        if (i_take && r_phase == PH_CSUM && i_rx_byte == r_sum) begin
            if (r_func == FN_RATE || r_func == FN_ATT) begin
                o_job_valid = 1'b1;
                o_job.kind  = JOB_GAINS;
            end else if (r_func >= FN_ACK_LO && r_func <= FN_ACK_HI) begin
                o_job_valid = 1'b1;
                o_job.kind  = JOB_ACK;
            end else if (r_func == FN_QUERY) begin
                if (n_store[0] == QRY_GAINS) begin
                    o_job_valid = 1'b1;
                    o_job.kind  = JOB_READ;
                end else if (n_store[0] == QRY_VERSION) begin
                    o_job_valid = 1'b1;
                    o_job.kind  = JOB_VERSION;
                end
            end
        end
    end

endmodule

### rtl/cfr_queue.sv
// Two-entry job queue between the frame parser and the result sequencer.
module cfr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cfr_pkg::t_job o_job
);
    import cfr_pkg::*;

    t_job       r_entry [QUEUE_DEPTH];
    logic       r_head, n_head;
    logic       r_tail, n_tail;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'(QUEUE_DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_entry[r_head];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_head  = do_pop  ? ~r_head : r_head;
        n_tail  = do_push ? ~r_tail : r_tail;
        n_count = 2'(r_count + 2'(do_push) - 2'(do_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_tail] <= i_job;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job offered while the queue is full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

### rtl/cfr_back.sv
// Result sequencer: walks a job; its output register gives one result per cycle while popped.
module cfr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_empty,
    input  cfr_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_ack_byte,
    output logic               o_gain_group,
    output logic [3:0]         o_gain_index,
    output logic signed [15:0] o_gain_value,
    output logic               o_last
);
    import cfr_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job, n_job;
    logic [3:0]  r_step, n_step;

    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_ack, n_ack;
    logic        r_group, n_group;
    logic [3:0]  r_index, n_index;
    logic [15:0] r_value, n_value;
    logic        r_last, n_last;

    logic        load;
    logic [2:0]  ack_pos;
    logic [7:0]  ack_byte;
    logic        res_last;

    assign ack_pos = 3'(r_step - ACK_FIRST_STEP);

    always_comb begin
        case (ack_pos)
            3'd0:    ack_byte = ACK_B0;
            3'd1:    ack_byte = ACK_B1;
            3'd2:    ack_byte = ACK_B2;
            3'd3:    ack_byte = ACK_B3;
            3'd4:    ack_byte = r_job.func;
            3'd5:    ack_byte = r_job.csum;
            default: ack_byte = 8'(ACK_CK_BASE + r_job.func + r_job.csum);
        endcase
    end

    assign res_last = (r_job.kind == JOB_READ) || (r_job.kind == JOB_VERSION) ||
                      (r_step == LAST_STEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_kind  <= n_kind;
        r_ack   <= n_ack;
        r_group <= n_group;
        r_index <= n_index;
        r_value <= n_value;
        r_last  <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_step      = r_step;
        n_kind      = r_kind;
        n_ack       = r_ack;
        n_group     = r_group;
        n_index     = r_index;
        n_value     = r_value;
        n_last      = r_last;
        o_job_pop   = 1'b0;
        load        = 1'b0;
        n_out_valid = r_out_valid && !i_pop;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_step    = (i_job.kind == JOB_GAINS) ? 4'd0 : ACK_FIRST_STEP;
                    n_state   = BK_RUN;
                end
            end
            BK_RUN: begin
                load = !r_out_valid || i_pop;
                if (load) begin
                    n_out_valid = 1'b1;
                    n_ack       = '0;
                    n_group     = 1'b0;
                    n_index     = '0;
                    n_value     = '0;
                    n_last      = res_last;
                    if (r_job.kind == JOB_READ) begin
                        n_kind = KIND_READ;
                    end else if (r_job.kind == JOB_VERSION) begin
                        n_kind = KIND_VERSION;
                    end else if (r_step < ACK_FIRST_STEP) begin
                        // Gain words leave the top of the payload, which then moves up.
                        n_kind        = KIND_GAIN;
                        n_group       = r_job.group;
                        n_index       = r_step;
                        n_value       = r_job.payload[PAYLOAD_W-1 -: 16];
                        n_job.payload = r_job.payload << 16;
                    end else begin
                        n_kind = KIND_ACK;
                        n_ack  = ack_byte;
                    end
                    if (res_last) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_step = r_step + 4'd1;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_empty      = !r_out_valid;
    assign o_kind       = r_kind;
    assign o_ack_byte   = r_ack;
    assign o_gain_group = r_group;
    assign o_gain_index = r_index;
    assign o_gain_value = r_value;
    assign o_last       = r_last;

    a_ack_job_skips_gains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RUN && r_job.kind == JOB_ACK) |-> r_step >= ACK_FIRST_STEP)
        else $error("acknowledge job entered the gain word steps");

    a_gain_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_GAIN) |-> r_index < 4'(GAIN_WORDS))
        else $error("gain index beyond the last slot");

    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RUN && load && res_last) |=> (r_state == BK_IDLE && o_last))
        else $error("sequencer kept running after the final result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |-> !load)
        else $error("waiting result overwritten");

endmodule

### rtl/command_frame_receiver_top.sv
// Top level of the command frame receiver: parser, job queue and result sequencer.
// The block takes one received byte per cycle whenever full is low; full rises only
// while the two-entry job queue holds two complete frames that are still waiting to be
// answered. A good frame is decoded in the cycle its checksum byte arrives. The sequencer
// fetches a job from the queue and then delivers one result item per cycle while pop is
// high: 16 items for a gain frame (nine gain words, then the seven acknowledge bytes),
// seven for an acknowledge-only frame, one for a readback or version request. Every other
// byte produces no result. The payload store is cleared by reset.
module command_frame_receiver_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_ack_byte,
    output logic               o_gain_group,
    output logic [3:0]         o_gain_index,
    output logic signed [15:0] o_gain_value,
    output logic               o_last
);
    import cfr_pkg::*;

    logic take;
    logic job_valid;
    t_job front_job;
    t_job head_job;
    logic job_empty;
    logic job_pop;

    assign take = push && !full;

    cfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx_byte),
        .o_job_valid (job_valid),
        .o_job       (front_job)
    );

    cfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_job   (head_job)
    );

    cfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_empty  (job_empty),
        .i_job        (head_job),
        .o_job_pop    (job_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_kind       (o_kind),
        .o_ack_byte   (o_ack_byte),
        .o_gain_group (o_gain_group),
        .o_gain_index (o_gain_index),
        .o_gain_value (o_gain_value),
        .o_last       (o_last)
    );

endmodule

### verif/frame_result_checker.sv
// Result checker for the command frame receiver: predicts every result and compares it.
module frame_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic [1:0]         i_kind,
    input  logic [7:0]         i_ack_byte,
    input  logic               i_gain_group,
    input  logic [3:0]         i_gain_index,
    input  logic signed [15:0] i_gain_value,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    import cfr_pkg::*;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         ack_byte;
        logic               gain_group;
        logic [3:0]         gain_index;
        logic signed [15:0] gain_value;
        logic               last;
    } t_reply;

    // Shadow copy of the parser state.
    t_phase     phase;
    logic [5:0] bytes_left;
    logic [5:0] payload_count;
    logic [7:0] running_sum;
    logic [7:0] function_code;
    logic [7:0] payload_store [STORE_DEPTH];

    t_reply awaited_replies [$];
    int     fail_count = 0;
    int     checked    = 0;

    function automatic string describe_reply(t_reply r);
        return $sformatf("kind %0d ack %02h group %0d index %0d value %0d last %0d",
                         r.kind, r.ack_byte, r.gain_group, r.gain_index, r.gain_value,
                         r.last);
    endfunction

    task automatic queue_reply(input logic [1:0] kind, input logic [7:0] ack_byte,
                               input logic gain_group, input logic [3:0] gain_index,
                               input logic [15:0] gain_value, input logic last);
        t_reply r;
        r.kind       = kind;
        r.ack_byte   = ack_byte;
        r.gain_group = gain_group;
        r.gain_index = gain_index;
        r.gain_value = gain_value;
        r.last       = last;
        awaited_replies.push_back(r);
    endtask

    task automatic queue_ack_frame();
        logic [7:0] ack_seq [6];
        logic [7:0] ck;
        int         i;
        ack_seq[0] = ACK_B0;
        ack_seq[1] = ACK_B1;
        ack_seq[2] = ACK_B2;
        ack_seq[3] = ACK_B3;
        ack_seq[4] = function_code;
        ack_seq[5] = running_sum;
        ck = 8'h00;
        for (i = 0; i < 6; i++) begin
            ck = ck + ack_seq[i];
            queue_reply(KIND_ACK, ack_seq[i], 1'b0, 4'd0, 16'd0, 1'b0);
        end
        queue_reply(KIND_ACK, ck, 1'b0, 4'd0, 16'd0, 1'b1);
    endtask

    task automatic act_on_frame();
        int k;
        if (function_code == FN_RATE || function_code == FN_ATT) begin
            for (k = 0; k < GAIN_WORDS; k++) begin
                queue_reply(KIND_GAIN, 8'h00, function_code[0], 4'(k),
                            {payload_store[2*k], payload_store[2*k+1]}, 1'b0);
            end
            queue_ack_frame();
        end else if (function_code >= FN_ACK_LO && function_code <= FN_ACK_HI) begin
            queue_ack_frame();
        end else if (function_code == FN_QUERY) begin
            if (payload_store[0] == QRY_GAINS) begin
                queue_reply(KIND_READ, 8'h00, 1'b0, 4'd0, 16'd0, 1'b1);
            end else if (payload_store[0] == QRY_VERSION) begin
                queue_reply(KIND_VERSION, 8'h00, 1'b0, 4'd0, 16'd0, 1'b1);
            end
        end
    endtask

    task automatic absorb_rx_byte(input logic [7:0] b);
        case (phase)
            PH_IDLE: begin
                if (b == HDR_FIRST) begin
                    phase       = PH_HDR2;
                    running_sum = b;
                end
            end
            PH_HDR2: begin
                if (b == HDR_SECOND) begin
                    phase       = PH_FUNC;
                    running_sum = running_sum + b;
                end else begin
                    phase = PH_IDLE;
                end
            end
            PH_FUNC: begin
                if (b < FUNC_LIMIT) begin
                    phase         = PH_LEN;
                    function_code = b;
                    running_sum   = running_sum + b;
                end else begin
                    phase = PH_IDLE;
                end
            end
            PH_LEN: begin
                if (b <= MAX_PAYLOAD) begin
                    phase         = PH_DATA;
                    bytes_left    = b[5:0];
                    payload_count = 6'd0;
                    running_sum   = running_sum + b;
                end else begin
                    phase = PH_IDLE;
                end
            end
            PH_DATA: begin
                // A zero length leaves nothing to count, so the next byte is dropped.
                if (bytes_left != 6'd0) begin
                    bytes_left = bytes_left - 6'd1;
                    if (payload_count < STORE_DEPTH) begin
                        payload_store[payload_count] = b;
                    end
                    payload_count = payload_count + 6'd1;
                    running_sum   = running_sum + b;
                    if (bytes_left == 6'd0) begin
                        phase = PH_CSUM;
                    end
                end else begin
                    phase = PH_IDLE;
                end
            end
            PH_CSUM: begin
                phase = PH_IDLE;
                // The checksum byte lands in the store too, just after the payload.
                if (payload_count < STORE_DEPTH) begin
                    payload_store[payload_count] = b;
                end
                if (b == running_sum) begin
                    act_on_frame();
                end
            end
            default: begin
                phase = PH_IDLE;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_reply seen;
        t_reply want;
        int     i;
        if (!i_rst_n) begin
            phase         = PH_IDLE;
            bytes_left    = 6'd0;
            payload_count = 6'd0;
            running_sum   = 8'h00;
            function_code = 8'h00;
            for (i = 0; i < STORE_DEPTH; i++) begin
                payload_store[i] = 8'h00;
            end
            awaited_replies.delete();
        end else begin
            // Results are compared before the byte of this edge is predicted; a byte
            // never produces a result in the cycle it is taken.
            if (i_pop && !i_empty) begin
                seen = {i_kind, i_ack_byte, i_gain_group, i_gain_index, i_gain_value, i_last};
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected result: %s", $time, describe_reply(seen));
                    fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (seen !== want) begin
                        $display("%0t: mismatch: expected %s, actual %s", $time,
                                 describe_reply(want), describe_reply(seen));
                        fail_count++;
                    end
                    checked++;
                end
            end
            if (i_push && !i_full) begin
                absorb_rx_byte(i_rx_byte);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= awaited_replies.size();
        o_checked    <= checked;
    end

endmodule

### verif/tb_top.sv
// Testbench top for the command frame receiver: clock, reset, frame stimulus and verdict.
module tb_top;
    import cfr_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int TOTAL_ITEMS  = 270;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_SUM,
        FLAW_CUT_SHORT,
        FLAW_BAD_HDR
    } t_flaw;

    typedef enum int {
        POP_ALWAYS,
        POP_HALF,
        POP_SPARSE,
        POP_PATTERN
    } t_pop_mode;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic push        = 1'b0;
    logic pop         = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic hold_request = 1'b0;

    logic               full;
    logic               empty;
    logic [1:0]         o_kind;
    logic [7:0]         o_ack_byte;
    logic               o_gain_group;
    logic [3:0]         o_gain_index;
    logic signed [15:0] o_gain_value;
    logic               o_last;

    int fail_count;
    int pending;
    int checked;

    logic [7:0] payload_buf [64];
    int burst_left  = 0;
    int bytes_sent  = 0;
    int frames_sent = 0;

    command_frame_receiver_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_rx_byte    (i_rx_byte),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_ack_byte   (o_ack_byte),
        .o_gain_group (o_gain_group),
        .o_gain_index (o_gain_index),
        .o_gain_value (o_gain_value),
        .o_last       (o_last)
    );

    frame_result_checker u_reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_rx_byte    (i_rx_byte),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_kind       (o_kind),
        .i_ack_byte   (o_ack_byte),
        .i_gain_group (o_gain_group),
        .i_gain_index (o_gain_index),
        .i_gain_value (o_gain_value),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The sender offers bytes in bursts and often pauses between them.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic fill_payload(input logic [7:0] first);
        int i;
        for (i = 0; i < 64; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0:       payload_buf[i] = 8'h00;
                    1:       payload_buf[i] = 8'hFF;
                    2:       payload_buf[i] = 8'h80;
                    default: payload_buf[i] = 8'h7F;
                endcase
            end else begin
                payload_buf[i] = 8'($urandom);
            end
        end
        payload_buf[0] = first;
    endtask

    task automatic send_frame(input logic [7:0] fn, input logic [7:0] len, input t_flaw flaw);
        logic [7:0] seq [$];
        logic [7:0] sum;
        int         n_data;
        int         keep;
        int         i;
        seq.delete();
        // An oversized length is rejected at once; two data bytes and the checksum follow it.
        n_data = (len > MAX_PAYLOAD) ? 2 : int'(len);
        seq.push_back(HDR_FIRST);
        if (flaw == FLAW_BAD_HDR) begin
            seq.push_back(HDR_SECOND ^ 8'($urandom_range(1, 255)));
        end else begin
            seq.push_back(HDR_SECOND);
        end
        seq.push_back(fn);
        seq.push_back(len);
        for (i = 0; i < n_data; i++) begin
            seq.push_back(payload_buf[i]);
        end
        sum = 8'h00;
        foreach (seq[i]) begin
            sum = sum + seq[i];
        end
        if (flaw == FLAW_BAD_SUM) begin
            sum = sum + 8'($urandom_range(1, 255));
        end
        seq.push_back(sum);
        keep = seq.size();
        if (flaw == FLAW_CUT_SHORT) begin
            keep = $urandom_range(1, seq.size() - 1);
        end
        for (i = 0; i < keep; i++) begin
            send_byte(seq[i]);
        end
        frames_sent++;
    endtask

    task automatic random_frame();
        int         sel;
        int         r;
        logic [7:0] fn;
        logic [7:0] len;
        logic [7:0] first;
        t_flaw      flaw;
        sel   = $urandom_range(0, 99);
        first = 8'($urandom);
        if (sel < 40) begin
            fn = (sel < 20) ? FN_RATE : FN_ATT;
            r  = $urandom_range(0, 99);
            if (r < 70)      len = 8'(STORE_DEPTH);
            else if (r < 85) len = 8'($urandom_range(1, STORE_DEPTH - 1));
            else if (r < 95) len = 8'($urandom_range(STORE_DEPTH + 1, 30));
            else             len = 8'(MAX_PAYLOAD);
        end else begin
            if (sel < 65) begin
                fn = FN_ACK_LO + 8'($urandom_range(0, 3));
            end else if (sel < 85) begin
                fn = FN_QUERY;
                case ($urandom_range(0, 2))
                    0:       first = QRY_GAINS;
                    1:       first = QRY_VERSION;
                    default: first = 8'($urandom);
                endcase
            end else begin
                fn = 8'($urandom_range(0, FUNC_LIMIT - 1));
            end
            r = $urandom_range(0, 99);
            if (r < 70)      len = 8'($urandom_range(1, 4));
            else if (r < 92) len = 8'($urandom_range(5, 20));
            else             len = 8'(MAX_PAYLOAD);
        end
        r = $urandom_range(0, 99);
        flaw = FLAW_NONE;
        if (r >= 85 && r < 90)      flaw = FLAW_BAD_SUM;
        else if (r >= 90 && r < 94) flaw = FLAW_CUT_SHORT;
        else if (r >= 94 && r < 96) flaw = FLAW_BAD_HDR;
        else if (r >= 96 && r < 98) fn = 8'($urandom_range(FUNC_LIMIT, 255));
        else if (r == 98)           len = 8'h00;
        else if (r == 99)           len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
        fill_payload(first);
        send_frame(fn, len, flaw);
    endtask

    // Receiver: switches between ready patterns, with one long hold-off on request.
    initial begin
        t_pop_mode mode;
        int        span;
        int        cyc;
        bit        hold_done;
        mode      = POP_ALWAYS;
        span      = 0;
        cyc       = 0;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (span == 0) begin
                    mode = t_pop_mode'($urandom_range(0, 3));
                    span = $urandom_range(20, 120);
                end
                span--;
                case (mode)
                    POP_ALWAYS:  pop <= 1'b1;
                    POP_HALF:    pop <= 1'($urandom_range(0, 1));
                    POP_SPARSE:  pop <= ($urandom_range(0, 4) == 0);
                    default:     pop <= ((cyc % 5) != 2) && ((cyc % 7) != 0);
                endcase
                cyc++;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [143:0] extremes;
        int           i;
        extremes = 144'h8000_7FFF_FFFF_0000_0001_8001_7FFE_1234_FEDC;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The receiver holds off while the first frames arrive, so the job queue fills.
        hold_request <= 1'b1;

        // Gain frame straight after reset: short, so it reads the cleared store.
        fill_payload(8'h00);
        send_frame(FN_RATE, 8'd1, FLAW_NONE);
        for (i = 0; i < STORE_DEPTH; i++) begin
            payload_buf[i] = extremes[143 - 8*i -: 8];
        end
        send_frame(FN_ATT, 8'(STORE_DEPTH), FLAW_NONE);
        fill_payload(8'h5A);
        send_frame(FN_ACK_LO, 8'd1, FLAW_NONE);
        send_frame(FN_ACK_HI, 8'd2, FLAW_NONE);
        fill_payload(QRY_GAINS);
        send_frame(FN_QUERY, 8'd1, FLAW_NONE);
        fill_payload(QRY_VERSION);
        send_frame(FN_QUERY, 8'd1, FLAW_NONE);
        fill_payload(8'h55);
        send_frame(FN_QUERY, 8'd1, FLAW_NONE);
        send_frame(FUNC_LIMIT - 8'd1, 8'd1, FLAW_NONE);
        send_frame(FN_ACK_LO, 8'd0, FLAW_NONE);
        send_frame(FN_RATE, 8'd4, FLAW_BAD_SUM);
        send_frame(FN_ACK_LO, 8'd1, FLAW_BAD_HDR);
        send_frame(FUNC_LIMIT, 8'd1, FLAW_NONE);
        send_frame(FN_ACK_LO, 8'(MAX_PAYLOAD + 1), FLAW_NONE);
        send_frame(FN_ACK_LO, 8'hFF, FLAW_NONE);
        // A repeated first header byte is a mismatch and is not taken as a new start.
        send_byte(HDR_FIRST);
        send_frame(FN_ACK_HI, 8'd1, FLAW_NONE);
        fill_payload(8'($urandom));
        send_frame(FN_RATE, 8'(MAX_PAYLOAD), FLAW_NONE);
        fill_payload(8'($urandom));
        send_frame(FN_ATT, 8'(STORE_DEPTH - 1), FLAW_NONE);

        while (bytes_sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 99) < 6) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end
            random_frame();
        end
        push <= 1'b0;

        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d frames in %0d bytes; %0d results checked, one long output hold.",
                 frames_sent, bytes_sent, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
rtl/cfr_pkg.sv
rtl/cfr_front.sv
rtl/cfr_queue.sv
rtl/cfr_back.sv
rtl/command_frame_receiver_top.sv
verif/frame_result_checker.sv
verif/tb_top.sv
